// ===== design/bede_pkg.sv =====
// Shared types, constants and arithmetic helpers of the diffusion estimator.
package bede_pkg;

  localparam int MAX_WALKERS = 65536;
  localparam int WIDX_W      = $clog2(MAX_WALKERS);
  localparam int CNT_W       = WIDX_W + 1;
  localparam int CFG_W       = 17;
  localparam int CIDX_W      = 2;
  localparam int NCMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [6:0] LEN_POS  = 7'd32;
  localparam logic [6:0] LEN_MEAN = 7'd48;
  localparam logic [6:0] LEN_DEN  = 7'd16;
  localparam logic [6:0] LEN_DIV  = 7'd64;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PARTICLE_COUNT = 2'd0,
    CFG_TIME_STEP      = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [6:0]  len;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [64:0] apply_sign(input logic [63:0] mag, input logic neg);
    logic signed [64:0] m;
    m = signed'({1'b0, mag});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v[64] != v[63]) begin
      r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    return clamp64(65'(a) + 65'(b));
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    return clamp64(65'(a) - 65'(b));
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/bede_if.sv =====
// Stream interfaces for walker steps and diffusion results.
interface bede_step_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] step_x;
  logic signed [23:0] step_y;
  modport source (output valid, output step_x, output step_y, input ready);
  modport sink (input valid, input step_x, input step_y, output ready);
endinterface

interface bede_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] diff_xx;
  logic signed [31:0] diff_yy;
  logic signed [31:0] diff_xy;
  logic        [15:0] sweep_number;
  modport source (output valid, output diff_xx, output diff_yy, output diff_xy,
                  output sweep_number, input ready);
  modport sink (input valid, input diff_xx, input diff_yy, input diff_xy,
                input sweep_number, output ready);
endinterface

// ===== design/bede_alu.sv =====
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit a cycle.
module bede_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bede_pkg::alu_req_t req_i,
  output bede_pkg::alu_rsp_t rsp_o
);
  import bede_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [6:0]  cnt_q;
  alu_op_e     op_q;
  logic [63:0] acc_q, acc_d;
  logic [63:0] mc_q, mc_d;
  logic [63:0] mp_q, mp_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] dv_q;
  logic [64:0] t;
  logic [65:0] diff;
  logic        ge;

  always_comb begin
    acc_d = acc_q;
    mc_d  = mc_q;
    mp_d  = mp_q;
    rem_d = rem_q;
    quo_d = quo_q;
    t     = {rem_q, quo_q[63]};
    diff  = {1'b0, t} - {2'b00, dv_q};
    ge    = !diff[65];
    case (op_q)
      ALU_MUL: begin
        acc_d = mp_q[0] ? acc_q + mc_q : acc_q;
        mc_d  = {mc_q[62:0], 1'b0};
        mp_d  = {1'b0, mp_q[63:1]};
      end
      ALU_DIV: begin
        rem_d = ge ? diff[63:0] : t[63:0];
        quo_d = {quo_q[62:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.len;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      mc_q  <= req_i.a;
      mp_q  <= req_i.b;
      rem_q <= '0;
      quo_q <= req_i.a;
      dv_q  <= req_i.b;
    end else if (busy_q) begin
      acc_q <= acc_d;
      mc_q  <= mc_d;
      mp_q  <= mp_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == ALU_MUL) ? acc_q : quo_q;

endmodule

// ===== design/brownian_ensemble_diffusion_estimator.sv =====
// Top level of the ensemble diffusion estimator for 2-D random walkers.
// A step that does not close a sweep runs three 32-bit products in the shared bit-serial
// unit; ready is low meanwhile.
// A step that closes a sweep adds five 64-bit divides by N, three 48-bit products, one
// 16-bit product and three 64-bit divides by 2t before the result.
// Reset clears control, sums and counters; positions read as zero until written
// (fill count), so there is no clearing pass.
module brownian_ensemble_diffusion_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bede_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [bede_pkg::CFG_W-1:0]   cfg_data_i,
  bede_step_if.sink                    step_if,
  bede_result_if.source                result_if
);
  import bede_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001, S_UPD = 18'h00002, S_MXX = 18'h00004, S_MXY = 18'h00008,
    S_MYY  = 18'h00010, S_MX  = 18'h00020, S_MY  = 18'h00040, S_QXX = 18'h00080,
    S_QYY  = 18'h00100, S_QXY = 18'h00200, S_PXX = 18'h00400, S_PYY = 18'h00800,
    S_PXY  = 18'h01000, S_DEN = 18'h02000, S_DXX = 18'h04000, S_DYY = 18'h08000,
    S_DXY  = 18'h10000, S_OUT = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic   neg_q, neg_d;

  logic [CFG_W-1:0]  pcount_q;
  logic [15:0]       tstep_q;
  logic [WIDX_W-1:0] walker_q;
  logic [CNT_W-1:0]  fill_q;
  logic [15:0]       sweep_q;

  logic signed [31:0] mem_x [MAX_WALKERS];
  logic signed [31:0] mem_y [MAX_WALKERS];
  logic signed [31:0] rd_x_q, rd_y_q;
  logic signed [23:0] sx_q, sy_q;
  logic signed [31:0] x_q, y_q;

  logic signed [47:0] sum_x_q, sum_y_q;
  logic signed [63:0] sum_xx_q, sum_yy_q, sum_xy_q;
  logic signed [47:0] mx_q, my_q;
  logic signed [63:0] mxx_q, myy_q, mxy_q;
  logic signed [63:0] cov_xx_q, cov_yy_q, cov_xy_q;
  logic [63:0]        den_q;
  logic signed [31:0] d_xx_q, d_yy_q, d_xy_q;

  logic               res_valid_q;
  logic signed [31:0] res_xx_q, res_yy_q, res_xy_q;
  logic [15:0]        res_sweep_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic               accept;
  logic               out_free;
  logic [NCMP_W-1:0]  n_wide;
  logic [CNT_W-1:0]   n_eff;
  logic [15:0]        ts_eff;
  logic               last;
  logic               entry_ok;
  logic signed [31:0] px, py;
  logic signed [31:0] x_new, y_new;
  logic signed [64:0] sval;
  logic [63:0]        den_new;

  function automatic logic signed [31:0] sat32(input logic signed [31:0] p,
                                               input logic signed [23:0] s);
    return clamp32(65'(p) + 65'(s));
  endfunction

  function automatic alu_req_t mk_req(input alu_op_e op, input logic [6:0] len,
                                      input logic [63:0] a, input logic [63:0] b);
    alu_req_t r;
    r.start = 1'b1;
    r.op    = op;
    r.len   = len;
    r.a     = a;
    r.b     = b;
    return r;
  endfunction

  bede_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign accept   = step_if.valid && step_if.ready;
  assign out_free = !res_valid_q || result_if.ready;

  always_comb begin
    if (pcount_q == '0) begin
      n_wide = NCMP_W'(1);
    end else if (NCMP_W'(pcount_q) > NCMP_W'(MAX_WALKERS)) begin
      n_wide = NCMP_W'(MAX_WALKERS);
    end else begin
      n_wide = NCMP_W'(pcount_q);
    end
  end
  assign n_eff    = n_wide[CNT_W-1:0];
  assign ts_eff   = (tstep_q == '0) ? 16'd1 : tstep_q;
  assign last     = (CNT_W'(walker_q) + CNT_W'(1)) >= n_eff;
  assign entry_ok = CNT_W'(walker_q) < fill_q;
  assign px       = entry_ok ? rd_x_q : '0;
  assign py       = entry_ok ? rd_y_q : '0;
  assign x_new    = sat32(px, sx_q);
  assign y_new    = sat32(py, sy_q);
  assign sval     = apply_sign(alu_rsp.result, neg_q);
  assign den_new  = {alu_rsp.result[62:0], 1'b0};

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    alu_req = '0;
    case (state_q)
      S_IDLE: if (accept) state_d = S_UPD;
      S_UPD: begin
        alu_req = mk_req(ALU_MUL, LEN_POS, abs64(64'(x_new)), abs64(64'(x_new)));
        neg_d   = 1'b0;
        state_d = S_MXX;
      end
      S_MXX: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_MUL, LEN_POS, abs64(64'(x_q)), abs64(64'(y_q)));
        neg_d   = x_q[31] ^ y_q[31];
        state_d = S_MXY;
      end
      S_MXY: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_MUL, LEN_POS, abs64(64'(y_q)), abs64(64'(y_q)));
        neg_d   = 1'b0;
        state_d = S_MYY;
      end
      S_MYY: if (alu_rsp.done) begin
        if (last) begin
          alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(64'(sum_x_q)), 64'(n_eff));
          neg_d   = sum_x_q[47];
          state_d = S_MX;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MX: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(64'(sum_y_q)), 64'(n_eff));
        neg_d   = sum_y_q[47];
        state_d = S_MY;
      end
      S_MY: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(sum_xx_q), 64'(n_eff));
        neg_d   = sum_xx_q[63];
        state_d = S_QXX;
      end
      S_QXX: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(sum_yy_q), 64'(n_eff));
        neg_d   = sum_yy_q[63];
        state_d = S_QYY;
      end
      S_QYY: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(sum_xy_q), 64'(n_eff));
        neg_d   = sum_xy_q[63];
        state_d = S_QXY;
      end
      S_QXY: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_MUL, LEN_MEAN, abs64(64'(mx_q)), abs64(64'(mx_q)));
        neg_d   = 1'b0;
        state_d = S_PXX;
      end
      S_PXX: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_MUL, LEN_MEAN, abs64(64'(my_q)), abs64(64'(my_q)));
        neg_d   = 1'b0;
        state_d = S_PYY;
      end
      S_PYY: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_MUL, LEN_MEAN, abs64(64'(mx_q)), abs64(64'(my_q)));
        neg_d   = mx_q[47] ^ my_q[47];
        state_d = S_PXY;
      end
      S_PXY: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_MUL, LEN_DEN, 64'(sweep_q), 64'(ts_eff));
        neg_d   = 1'b0;
        state_d = S_DEN;
      end
      S_DEN: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(cov_xx_q), den_new);
        neg_d   = cov_xx_q[63];
        state_d = S_DXX;
      end
      S_DXX: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(cov_yy_q), den_q);
        neg_d   = cov_yy_q[63];
        state_d = S_DYY;
      end
      S_DYY: if (alu_rsp.done) begin
        alu_req = mk_req(ALU_DIV, LEN_DIV, abs64(cov_xy_q), den_q);
        neg_d   = cov_xy_q[63];
        state_d = S_DXY;
      end
      S_DXY: if (alu_rsp.done) state_d = S_OUT;
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      pcount_q    <= CFG_W'(65536);
      tstep_q     <= 16'd655;
      walker_q    <= '0;
      fill_q      <= '0;
      sweep_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_xx_q    <= '0;
      sum_yy_q    <= '0;
      sum_xy_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PARTICLE_COUNT) pcount_q <= cfg_data_i;
        if (cfg_idx_i == CFG_TIME_STEP) tstep_q <= cfg_data_i[15:0];
      end
      if (state_q == S_OUT && out_free) begin
        res_valid_q <= 1'b1;
      end else if (result_if.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_UPD: begin
          sum_x_q <= clamp64(65'(sum_x_q) + 65'(x_new)) > 64'sh7FFFFFFFFFFF ?
                     48'sh7FFFFFFFFFFF :
                     (clamp64(65'(sum_x_q) + 65'(x_new)) < -64'sh800000000000 ?
                      48'sh800000000000 : 48'(sum_x_q + 48'(x_new)));
          sum_y_q <= clamp64(65'(sum_y_q) + 65'(y_new)) > 64'sh7FFFFFFFFFFF ?
                     48'sh7FFFFFFFFFFF :
                     (clamp64(65'(sum_y_q) + 65'(y_new)) < -64'sh800000000000 ?
                      48'sh800000000000 : 48'(sum_y_q + 48'(y_new)));
          if (CNT_W'(walker_q) == fill_q) fill_q <= fill_q + CNT_W'(1);
        end
        S_MXX: if (alu_rsp.done) sum_xx_q <= sat_add64(sum_xx_q, sval[63:0]);
        S_MXY: if (alu_rsp.done) sum_xy_q <= sat_add64(sum_xy_q, sval[63:0]);
        S_MYY: if (alu_rsp.done) begin
          sum_yy_q <= sat_add64(sum_yy_q, sval[63:0]);
          if (last) begin
            if (sweep_q != 16'hFFFF) sweep_q <= sweep_q + 16'd1;
          end else begin
            walker_q <= walker_q + WIDX_W'(1);
          end
        end
        S_OUT: if (out_free) begin
          walker_q    <= '0;
          sum_x_q     <= '0;
          sum_y_q     <= '0;
          sum_xx_q    <= '0;
          sum_yy_q    <= '0;
          sum_xy_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q   <= step_if.step_x;
      sy_q   <= step_if.step_y;
      rd_x_q <= mem_x[walker_q];
      rd_y_q <= mem_y[walker_q];
    end
    if (state_q == S_UPD) begin
      mem_x[walker_q] <= x_new;
      mem_y[walker_q] <= y_new;
      x_q             <= x_new;
      y_q             <= y_new;
    end
    if (alu_rsp.done) begin
      case (state_q)
        S_MX:  mx_q     <= sval[47:0];
        S_MY:  my_q     <= sval[47:0];
        S_QXX: mxx_q    <= sval[63:0];
        S_QYY: myy_q    <= sval[63:0];
        S_QXY: mxy_q    <= sval[63:0];
        S_PXX: cov_xx_q <= sat_sub64(mxx_q, sval[63:0]);
        S_PYY: cov_yy_q <= sat_sub64(myy_q, sval[63:0]);
        S_PXY: cov_xy_q <= sat_sub64(mxy_q, sval[63:0]);
        S_DEN: den_q    <= den_new;
        S_DXX: d_xx_q   <= clamp32(sval);
        S_DYY: d_yy_q   <= clamp32(sval);
        S_DXY: d_xy_q   <= clamp32(sval);
        default: ;
      endcase
    end
    if (state_q == S_OUT && out_free) begin
      res_xx_q    <= d_xx_q;
      res_yy_q    <= d_yy_q;
      res_xy_q    <= d_xy_q;
      res_sweep_q <= sweep_q;
    end
  end

  assign step_if.ready          = (state_q == S_IDLE);
  assign result_if.valid        = res_valid_q;
  assign result_if.diff_xx      = res_xx_q;
  assign result_if.diff_yy      = res_yy_q;
  assign result_if.diff_xy      = res_xy_q;
  assign result_if.sweep_number = res_sweep_q;

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_UPD)
    else $error("accepted transaction did not start an update");

  a_walker_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(walker_q) <= fill_q)
    else $error("walker index beyond written positions");

  a_sweep_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> (walker_q == '0 && sum_x_q == '0 && sum_xx_q == '0))
    else $error("sweep state not cleared with result");

  a_alu_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> (state_q != S_IDLE && state_q != S_OUT))
    else $error("unit started outside of a computing state");

endmodule

// ===== verif/tb.sv =====
// Testbench for the ensemble diffusion estimator, with a self-checking sweep predictor.
`timescale 1ns / 1ps

module tb;
  import bede_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam longint SUM48_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM48_LO = -SUM48_HI - 1;
  localparam longint I64_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_LO = -I64_HI - 1;
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;
  localparam logic signed [23:0] STEP_HI = 24'sh7FFFFF;
  localparam logic signed [23:0] STEP_LO = 24'sh800000;

  typedef struct {
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] xy;
    logic [15:0]        sweep;
  } sweep_result_t;

  class diffusion_scoreboard;
    int unsigned   walker_cnt;
    int unsigned   dt;
    int            pos_x [MAX_WALKERS];
    int            pos_y [MAX_WALKERS];
    int unsigned   widx;
    int unsigned   sweeps;
    longint        sx, sy, sxy, sxx, syy;
    sweep_result_t pending_q[$];
    int            errors;

    function new();
      walker_cnt = 65536;
      dt = 655;
      foreach (pos_x[i]) begin
        pos_x[i] = 0;
        pos_y[i] = 0;
      end
      widx = 0;
      sweeps = 0;
      sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_PARTICLE_COUNT) walker_cnt = val;
      else if (idx == CFG_TIME_STEP) dt = val[15:0];
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sat_sum(longint a, longint b, bit sub);
      logic signed [64:0] s;
      s = a;
      s = sub ? s - b : s + b;
      if (s > I64_HI) return I64_HI;
      if (s < I64_LO) return I64_LO;
      return longint'(s);
    endfunction

    function logic signed [31:0] coeff(longint s_ab, longint s_a, longint s_b,
                                       longint n, longint den);
      longint ma, mb, mab, cov;
      ma = s_a / n;
      mb = s_b / n;
      mab = s_ab / n;
      cov = sat_sum(mab, ma * mb, 1'b1);
      return 32'(clip(cov / den, I32_LO, I32_HI));
    endfunction

    function void note_step(logic signed [23:0] stx, logic signed [23:0] sty);
      int unsigned   n, ts, w;
      longint        x, y, den;
      sweep_result_t r;
      n = walker_cnt;
      if (n == 0) n = 1;
      if (n > MAX_WALKERS) n = MAX_WALKERS;
      ts = (dt == 0) ? 1 : dt;
      w = widx;
      if (w >= MAX_WALKERS) w = MAX_WALKERS - 1;
      x = clip(longint'(pos_x[w]) + longint'(stx), I32_LO, I32_HI);
      y = clip(longint'(pos_y[w]) + longint'(sty), I32_LO, I32_HI);
      pos_x[w] = int'(x);
      pos_y[w] = int'(y);
      sx = clip(sx + x, SUM48_LO, SUM48_HI);
      sy = clip(sy + y, SUM48_LO, SUM48_HI);
      sxy = sat_sum(sxy, x * y, 1'b0);
      sxx = sat_sum(sxx, x * x, 1'b0);
      syy = sat_sum(syy, y * y, 1'b0);
      if (w + 1 < n) begin
        widx = w + 1;
        return;
      end
      if (sweeps < 65535) sweeps++;
      den = 2 * longint'(sweeps) * longint'(ts);
      r.xx = coeff(sxx, sx, sx, n, den);
      r.yy = coeff(syy, sy, sy, n, den);
      r.xy = coeff(sxy, sx, sy, n, den);
      r.sweep = sweeps[15:0];
      pending_q.push_back(r);
      widx = 0;
      sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
    endfunction

    function void check_sweep(logic signed [31:0] xx, logic signed [31:0] yy,
                              logic signed [31:0] xy, logic [15:0] sn);
      sweep_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result xx=%0d yy=%0d xy=%0d sweep=%0d",
                 $time, xx, yy, xy, sn);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (xx !== e.xx) begin
        $display("%0t: diff_xx expected %0d actual %0d", $time, e.xx, xx);
        errors++;
      end
      if (yy !== e.yy) begin
        $display("%0t: diff_yy expected %0d actual %0d", $time, e.yy, yy);
        errors++;
      end
      if (xy !== e.xy) begin
        $display("%0t: diff_xy expected %0d actual %0d", $time, e.xy, xy);
        errors++;
      end
      if (sn !== e.sweep) begin
        $display("%0t: sweep_number expected %0d actual %0d", $time, e.sweep, sn);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CIDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  int                 tx_max_gap;
  int                 rx_max_gap;
  diffusion_scoreboard sb;

  bede_step_if   step_bus ();
  bede_result_if res_bus ();

  brownian_ensemble_diffusion_estimator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_if    (step_bus),
    .result_if  (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("brownian_ensemble_diffusion_estimator verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_step(input logic signed [23:0] stx, input logic signed [23:0] sty);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      step_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    step_bus.valid  <= 1'b1;
    step_bus.step_x <= stx;
    step_bus.step_y <= sty;
    do @(posedge clk_i); while (!step_bus.ready);
    sb.note_step(stx, sty);
  endtask

  // hold the sender until every pending sweep result is back, then let in-flight steps finish
  task automatic drain();
    int guard;
    step_bus.valid <= 1'b0;
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] rand_step();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? STEP_HI : STEP_LO;
      default: return 24'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  initial begin
    res_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int stall;
      stall = $urandom_range(0, rx_max_gap);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      sb.check_sweep(res_bus.diff_xx, res_bus.diff_yy, res_bus.diff_xy,
                     res_bus.sweep_number);
    end
  end

  initial begin
    int unsigned pc;
    sb = new();
    tx_max_gap = 8;
    rx_max_gap = 8;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_PARTICLE_COUNT;
    cfg_data_i      <= '0;
    step_bus.valid  <= 1'b0;
    step_bus.step_x <= '0;
    step_bus.step_y <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_PARTICLE_COUNT, 17'd1);
    write_reg(CFG_TIME_STEP, 17'd0);
    send_step(STEP_HI, STEP_HI);
    send_step(STEP_LO, STEP_LO);
    send_step(STEP_HI, STEP_LO);
    send_step(24'sd0, 24'sd0);
    send_step(24'sh555555, 24'shAAAAAA);
    drain();
    write_reg(CFG_PARTICLE_COUNT, 17'd0);
    write_reg(CFG_TIME_STEP, 17'd65535);
    send_step(STEP_LO, STEP_HI);
    send_step(24'sd65536, -24'sd65536);
    drain();
    write_reg(CFG_PARTICLE_COUNT, 17'd3);
    write_reg(CFG_TIME_STEP, 17'd1);
    write_reg(CFG_IDX_UNUSED, 17'h1FFFF);
    repeat (6) send_step(rand_step(), rand_step());
    drain();
    // oversized count, then lowered below the current walker mid-sweep
    write_reg(CFG_PARTICLE_COUNT, 17'h1FFFF);
    repeat (5) send_step(rand_step(), rand_step());
    drain();
    write_reg(CFG_PARTICLE_COUNT, 17'd2);
    write_reg(CFG_TIME_STEP, 17'd655);
    repeat (3) send_step(rand_step(), rand_step());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: pc = $urandom_range(1, 8);
        1: pc = $urandom_range(0, 2);
        2: pc = $urandom_range(9, 31);
        default: pc = $urandom_range(1, 4);
      endcase
      write_reg(CFG_PARTICLE_COUNT, 17'(pc));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_TIME_STEP, 17'd1);
        1: write_reg(CFG_TIME_STEP, 17'd65535);
        default: write_reg(CFG_TIME_STEP, 17'($urandom_range(0, 65535)));
      endcase
      tx_max_gap = (ph == 2) ? 0 : 8;
      rx_max_gap = (ph == 5) ? 0 : 8;
      repeat (100) send_step(rand_step(), rand_step());
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("brownian_ensemble_diffusion_estimator verification clean");
    end else begin
      if (sb.pending_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
      $display("brownian_ensemble_diffusion_estimator verification failed");
    end
    $finish;
  end

endmodule
